/* sv/appf_pkg.sv */
`timescale 1ns / 1ps

package appf_pkg;

  localparam int MaxFieldChars = 9;
  localparam int FractionBits  = 8;
  localparam int GainWidth     = 9;
  localparam logic [GainWidth-1:0] GainReset = 9'd230;

  localparam int Sat24Max = 8388607;
  localparam int Sat24Min = -8388608;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharBang  = 8'h21;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharAt    = 8'h40;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;

  typedef struct packed {
    logic en;
    logic feed;
    logic clear;
  } field_ctl_t;

endpackage

/* sv/appf_field.sv */
`timescale 1ns / 1ps

module appf_field #(
  parameter int MaxChars = appf_pkg::MaxFieldChars,
  parameter bit Negate   = 1'b0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  appf_pkg::field_ctl_t   ctl_i,
  input  logic [7:0]             byte_i,
  output logic signed [15:0]     value_o
);

  localparam int CntW = $clog2(MaxChars + 1);

  typedef enum logic [1:0] {
    PhSkip,
    PhNum,
    PhDone
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              neg_q, neg_d;
  logic [15:0]       acc_q, acc_d;
  logic              is_digit, is_space;
  logic [15:0]       acc_step;
  logic [15:0]       signed_acc;

  assign is_digit = (byte_i inside {[appf_pkg::CharZero:appf_pkg::CharNine]});
  assign is_space = (byte_i == appf_pkg::CharSpace) ||
                    (byte_i inside {[appf_pkg::CharTab:appf_pkg::CharCr]});
  assign acc_step = (acc_q << 3) + (acc_q << 1) + {12'd0, byte_i[3:0]};

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    if (ctl_i.feed && (count_q < CntW'(MaxChars))) begin
      count_d = count_q + 1'b1;
      case (phase_q)
        PhSkip: begin
          if (is_space) begin
            phase_d = PhSkip;
          end else if ((byte_i == appf_pkg::CharPlus) || (byte_i == appf_pkg::CharMinus)) begin
            neg_d   = (byte_i == appf_pkg::CharMinus);
            phase_d = PhNum;
          end else if (is_digit) begin
            acc_d   = acc_step;
            phase_d = PhNum;
          end else begin
            phase_d = PhDone;
          end
        end
        PhNum: begin
          if (is_digit) begin
            acc_d = acc_step;
          end else begin
            phase_d = PhDone;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // The sign and the optional negation cancel when both apply.
  assign signed_acc = (neg_d ^ Negate) ? (16'd0 - acc_d) : acc_d;
  assign value_o    = $signed(signed_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSkip;
      count_q <= '0;
      neg_q   <= 1'b0;
      acc_q   <= '0;
    end else if (ctl_i.en) begin
      if (ctl_i.clear) begin
        phase_q <= PhSkip;
        count_q <= '0;
        neg_q   <= 1'b0;
        acc_q   <= '0;
      end else begin
        phase_q <= phase_d;
        count_q <= count_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
      end
    end
  end

endmodule

/* sv/appf_filter.sv */
`timescale 1ns / 1ps

module appf_filter #(
  parameter int FracBits = appf_pkg::FractionBits
) (
  input  logic signed [23:0]                  kept_i,
  input  logic signed [15:0]                  sample_i,
  input  logic [appf_pkg::GainWidth-1:0]      gain_i,
  output logic signed [23:0]                  next_o
);

  localparam int SW  = 16 + FracBits;
  localparam int SWX = (SW > 25) ? SW : 25;
  localparam logic signed [SWX-1:0] SMax = SWX'(appf_pkg::Sat24Max);
  localparam logic signed [SWX-1:0] SMin = SWX'(appf_pkg::Sat24Min);
  localparam logic signed [27:0]    RMax = 28'(appf_pkg::Sat24Max);
  localparam logic signed [27:0]    RMin = 28'(appf_pkg::Sat24Min);

  logic signed [SW-1:0]  scaled;
  logic signed [SWX-1:0] scaled_x;
  logic signed [23:0]    sample24;
  logic signed [24:0]    err;
  logic signed [34:0]    prod;
  logic signed [27:0]    sum;

  assign scaled   = $signed({sample_i, {FracBits{1'b0}}});
  assign scaled_x = SWX'(scaled);

  always_comb begin
    if (scaled_x > SMax) begin
      sample24 = SMax[23:0];
    end else if (scaled_x < SMin) begin
      sample24 = SMin[23:0];
    end else begin
      sample24 = scaled_x[23:0];
    end
  end

  assign err  = 25'(sample24) - 25'(kept_i);
  assign prod = 35'(err) * $signed({1'b0, gain_i});
  assign sum  = 28'(kept_i) + 28'($signed(prod[34:8]));

  always_comb begin
    if (sum > RMax) begin
      next_o = RMax[23:0];
    end else if (sum < RMin) begin
      next_o = RMin[23:0];
    end else begin
      next_o = sum[23:0];
    end
  end

endmodule

/* sv/ascii_point_pair_parser_filter_core.sv */
`timescale 1ns / 1ps

// Parses messages of the form "!x,y@" arriving one byte per item on the input
// channel, with last_byte_i marking the final byte of each message. Only the
// final byte of a message produces a result item on the output channel; it
// carries packet_ok_o and the low-pass filtered x and negated y values in
// signed fixed point. A bad packet leaves the filters unchanged and reports
// the held values.
// One input item is accepted per cycle unless in_stall_o is high. The marker
// flags and both field parsers update in the cycle of acceptance; a last byte's
// values are registered in the sample stage, then filtered into the output
// registers. A new message may start in the cycle after a last byte. When the
// receiver stalls a waiting result, the input channel stalls as well until the
// result is taken. Reset clears all parse state, both filters and the pipeline
// valid flags, and sets the gain register to 230. The user writes the gain via
// cfg_we_i and cfg_wdata_i only while the block is idle; nothing enforces this.

module ascii_point_pair_parser_filter_core #(
  parameter int MaxFieldChars = appf_pkg::MaxFieldChars,
  parameter int FractionBits  = appf_pkg::FractionBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [appf_pkg::GainWidth-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        data_byte_i,
  input  logic                              last_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              packet_ok_o,
  output logic signed [23:0]                filtered_x_o,
  output logic signed [23:0]                filtered_y_o
);

  typedef struct packed {
    logic bad;
    logic at;
    logic comma;
    logic bang;
    logic zero;
  } flags_t;

  logic [appf_pkg::GainWidth-1:0] gain_q;
  flags_t                          flags_q, flags_d;
  logic                            advance, accept;
  logic                            feed_x, feed_y;
  appf_pkg::field_ctl_t            ctl_x, ctl_y;
  logic signed [15:0]              x_val, y_val;
  logic                            ok_d;

  logic                            smp_valid_q, smp_ok_q;
  logic signed [15:0]              smp_x_q, smp_y_q;
  logic                            out_valid_q, ok_q;
  logic signed [23:0]              filt_x_q, filt_y_q;
  logic signed [23:0]              filt_x_d, filt_y_d;

  assign advance    = !(out_valid_q && out_stall_i);
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  always_comb begin
    flags_d = flags_q;
    feed_x  = 1'b0;
    feed_y  = 1'b0;
    if (!flags_q.zero) begin
      if (data_byte_i == appf_pkg::CharNul) begin
        flags_d.zero = 1'b1;
      end else if ((data_byte_i == appf_pkg::CharBang) && !flags_q.bang) begin
        if (flags_q.comma || flags_q.at) begin
          flags_d.bad = 1'b1;
        end
        flags_d.bang = 1'b1;
      end else if ((data_byte_i == appf_pkg::CharComma) && !flags_q.comma) begin
        if (!flags_q.bang || flags_q.at) begin
          flags_d.bad = 1'b1;
        end
        flags_d.comma = 1'b1;
      end else if ((data_byte_i == appf_pkg::CharAt) && !flags_q.at) begin
        if (!flags_q.comma) begin
          flags_d.bad = 1'b1;
        end
        flags_d.at = 1'b1;
      end else if (flags_q.bang && !flags_q.comma) begin
        feed_x = 1'b1;
      end else if (flags_q.comma && !flags_q.at) begin
        feed_y = 1'b1;
      end
    end
  end

  assign ok_d = flags_d.bang && flags_d.comma && flags_d.at && !flags_d.bad;

  assign ctl_x = '{en: accept, feed: feed_x, clear: last_byte_i};
  assign ctl_y = '{en: accept, feed: feed_y, clear: last_byte_i};

  appf_field #(
    .MaxChars (MaxFieldChars),
    .Negate   (1'b0)
  ) u_field_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_x),
    .byte_i  (data_byte_i),
    .value_o (x_val)
  );

  appf_field #(
    .MaxChars (MaxFieldChars),
    .Negate   (1'b1)
  ) u_field_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_y),
    .byte_i  (data_byte_i),
    .value_o (y_val)
  );

  appf_filter #(
    .FracBits (FractionBits)
  ) u_filter_x (
    .kept_i   (filt_x_q),
    .sample_i (smp_x_q),
    .gain_i   (gain_q),
    .next_o   (filt_x_d)
  );

  appf_filter #(
    .FracBits (FractionBits)
  ) u_filter_y (
    .kept_i   (filt_y_q),
    .sample_i (smp_y_q),
    .gain_i   (gain_q),
    .next_o   (filt_y_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= appf_pkg::GainReset;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (accept) begin
      flags_q <= last_byte_i ? '0 : flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      filt_x_q    <= '0;
      filt_y_q    <= '0;
    end else if (advance) begin
      smp_valid_q <= accept && last_byte_i;
      out_valid_q <= smp_valid_q;
      if (smp_valid_q && smp_ok_q) begin
        filt_x_q <= filt_x_d;
        filt_y_q <= filt_y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_byte_i) begin
      smp_ok_q <= ok_d;
      smp_x_q  <= x_val;
      smp_y_q  <= y_val;
    end
    if (advance && smp_valid_q) begin
      ok_q <= smp_ok_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign packet_ok_o  = ok_q;
  assign filtered_x_o = filt_x_q;
  assign filtered_y_o = filt_y_q;

endmodule
